### rtl/core/visca_command_frame_encoder_top_macros.svh
// Assertion macros used by the encoder checker file.
`ifndef VISCA_COMMAND_FRAME_ENCODER_TOP_MACROS_SVH
`define VISCA_COMMAND_FRAME_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, muted during reset.
`define VCFE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame encoder check failed");

// Next-cycle implication, sampled on clk, muted during reset.
`define VCFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame encoder check failed");

`endif

### rtl/core/vcfe_pkg.sv
// Shared types and constants of the camera command frame encoder.
package vcfe_pkg;

  localparam int BYTE_W         = 8;
  localparam int BODY_MAX       = 8;   // bytes before the terminator, worst case
  localparam int LEN_W          = 4;   // holds 0..BODY_MAX
  localparam int CFG_INDEX_W    = 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] HDR_BASE   = 8'h80;
  localparam logic [7:0] TERMINATOR = 8'hFF;
  localparam logic [7:0] PAN_MAX    = 8'h18;
  localparam logic [7:0] TILT_MAX   = 8'h14;
  localparam logic [7:0] ZOOM_MAX   = 8'h07;
  localparam logic [7:0] STOP_CODE_RESET = 8'h03;

  typedef enum logic [3:0] {
    OP_PANTILT       = 4'd0,
    OP_STOP          = 4'd1,
    OP_HOME          = 4'd2,
    OP_ZOOM          = 4'd3,
    OP_FOCUS         = 4'd4,
    OP_AUTOFOCUS     = 4'd5,
    OP_POWER         = 4'd6,
    OP_PRESET_SET    = 4'd7,
    OP_PRESET_RECALL = 4'd8
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAN_STOP  = 2'd0,
    REG_TILT_STOP = 2'd1
  } reg_index_t;

  // One queued frame: body bytes in order plus body length (terminator implied).
  typedef struct packed {
    logic [BODY_MAX-1:0][BYTE_W-1:0] body;
    logic [LEN_W-1:0]                len;
  } frame_t;

endpackage

### rtl/core/vcfe_front.sv
// Front end: classifies a command request and builds its frame body.
module vcfe_front import vcfe_pkg::*; (
  input  logic              in_valid,
  input  logic              queue_full,
  input  logic [3:0]        in_operation,
  input  logic [3:0]        in_camera_address,
  input  logic [7:0]        in_pan_code,
  input  logic [7:0]        in_tilt_code,
  input  logic [7:0]        in_pan_rate,
  input  logic [7:0]        in_tilt_rate,
  input  logic signed [7:0] in_direction,
  input  logic [7:0]        in_zoom_rate,
  input  logic              in_enable,
  input  logic [7:0]        in_preset_number,
  input  logic [7:0]        pan_stop_code,
  input  logic [7:0]        tilt_stop_code,
  output logic              push_valid,
  output frame_t            push_frame
);

  logic       known;
  logic       dir_neg;
  logic       dir_pos;
  logic [7:0] pan_speed;
  logic [7:0] tilt_speed;
  logic [2:0] zoom_speed;
  logic [7:0] en_byte;

  assign dir_neg    = in_direction[7];
  assign dir_pos    = !dir_neg && (in_direction != 8'sd0);
  assign en_byte    = in_enable ? 8'h02 : 8'h03;
  assign zoom_speed = (in_zoom_rate > ZOOM_MAX) ? ZOOM_MAX[2:0] : in_zoom_rate[2:0];

  always_comb begin
    if (in_pan_rate == 8'd0) pan_speed = 8'd1;
    else if (in_pan_rate > PAN_MAX) pan_speed = PAN_MAX;
    else pan_speed = in_pan_rate;
    if (in_tilt_rate == 8'd0) tilt_speed = 8'd1;
    else if (in_tilt_rate > TILT_MAX) tilt_speed = TILT_MAX;
    else tilt_speed = in_tilt_rate;
  end

  always_comb begin
    push_frame         = '0;
    known              = 1'b1;
    push_frame.body[0] = HDR_BASE | {4'h0, in_camera_address};
    push_frame.body[1] = 8'h01;
    unique case (op_t'(in_operation)) inside
      OP_PANTILT: begin
        push_frame.body[2] = 8'h06;
        push_frame.body[3] = 8'h01;
        push_frame.body[4] = pan_speed;
        push_frame.body[5] = tilt_speed;
        push_frame.body[6] = in_pan_code;
        push_frame.body[7] = in_tilt_code;
        push_frame.len     = LEN_W'(8);
      end
      OP_STOP: begin
        push_frame.body[2] = 8'h06;
        push_frame.body[3] = 8'h01;
        push_frame.body[4] = 8'h01;
        push_frame.body[5] = 8'h01;
        push_frame.body[6] = pan_stop_code;
        push_frame.body[7] = tilt_stop_code;
        push_frame.len     = LEN_W'(8);
      end
      OP_HOME: begin
        push_frame.body[2] = 8'h06;
        push_frame.body[3] = 8'h04;
        push_frame.len     = LEN_W'(4);
      end
      OP_ZOOM: begin
        push_frame.body[2] = 8'h04;
        push_frame.body[3] = 8'h07;
        if (dir_pos) push_frame.body[4] = {5'b00100, zoom_speed};
        else if (dir_neg) push_frame.body[4] = {5'b00110, zoom_speed};
        else push_frame.body[4] = 8'h00;
        push_frame.len     = LEN_W'(5);
      end
      OP_FOCUS: begin
        push_frame.body[2] = 8'h04;
        push_frame.body[3] = 8'h08;
        if (dir_pos) push_frame.body[4] = 8'h02;
        else if (dir_neg) push_frame.body[4] = 8'h03;
        else push_frame.body[4] = 8'h00;
        push_frame.len     = LEN_W'(5);
      end
      OP_AUTOFOCUS: begin
        push_frame.body[2] = 8'h04;
        push_frame.body[3] = 8'h38;
        push_frame.body[4] = en_byte;
        push_frame.len     = LEN_W'(5);
      end
      OP_POWER: begin
        push_frame.body[2] = 8'h04;
        push_frame.body[3] = 8'h00;
        push_frame.body[4] = en_byte;
        push_frame.len     = LEN_W'(5);
      end
      OP_PRESET_SET, OP_PRESET_RECALL: begin
        push_frame.body[2] = 8'h04;
        push_frame.body[3] = 8'h3F;
        push_frame.body[4] = (op_t'(in_operation) == OP_PRESET_SET) ? 8'h01 : 8'h02;
        push_frame.body[5] = {1'b0, in_preset_number[6:0]};
        push_frame.len     = LEN_W'(6);
      end
      default: known = 1'b0;  // unknown codes are swallowed
    endcase
  end

  assign push_valid = in_valid && !queue_full && known;

endmodule

### rtl/core/vcfe_queue.sv
// Small frame queue between the front end and the byte serializer.
module vcfe_queue import vcfe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_frame;
  end

endmodule

### rtl/core/vcfe_back.sv
// Back end: walks a frame one byte per transfer into the output register.
module vcfe_back import vcfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  frame_t     head,
  input  logic       queue_empty,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  frame_t           cur_r;
  logic             busy_r;
  logic [LEN_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             advance;
  logic             at_term;

  assign advance = !out_valid_r || !out_stall;
  assign at_term = (idx_r == cur_r.len);
  assign pop     = !queue_empty && (!busy_r || (advance && at_term));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (advance) out_valid_r <= busy_r;
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (advance && busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (at_term) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy_r) begin
      out_byte_r <= at_term ? TERMINATOR : cur_r.body[idx_r[$clog2(BODY_MAX)-1:0]];
      out_last_r <= at_term;
    end
    if (pop) cur_r <= head;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule

### rtl/core/visca_command_frame_encoder_top.sv
// Top level of the camera command frame encoder.
//
// Usage:
//   Input channel (in_*): one camera command request per transfer, taken at a
//   clock edge with in_valid high and in_stall low. in_stall rises only while
//   the frame queue is full.
//   Output channel (out_*): the command frame, one byte per transfer, with
//   out_last_byte set on the 0xFF terminator. The sink holds out_stall high
//   to freeze the current byte; the front keeps accepting until the queue
//   fills.
//   Config channel (cfg_*): always ready; index 0 writes the pan stop code,
//   index 1 the tilt stop code, other indexes are dropped. Write while idle.
// Path: queue, then serializer frame register, then output byte register.
// Throughput: one byte per cycle while out_stall is low; a frame is 5 to 9
//   bytes (home 5, zoom/focus/af/power 6, preset 7, pan/tilt and stop 9),
//   sent by the serializer in the back end. Queued frames follow with no gap.
// Unknown operation codes are accepted and produce no bytes.
// Reset (rst_n low, synchronous): queue and serializer empty, both stop codes
//   return to 0x03.
module visca_command_frame_encoder_top import vcfe_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // frames buffered, 2 or more
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command requests
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             in_operation,
  input  logic [3:0]             in_camera_address,
  input  logic [7:0]             in_pan_code,
  input  logic [7:0]             in_tilt_code,
  input  logic [7:0]             in_pan_rate,
  input  logic [7:0]             in_tilt_rate,
  input  logic signed [7:0]      in_direction,
  input  logic [7:0]             in_zoom_rate,
  input  logic                   in_enable,
  input  logic [7:0]             in_preset_number,
  // frame bytes
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_frame_byte,
  output logic                   out_last_byte,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_wdata
);

  logic [7:0] pan_stop_r;
  logic [7:0] tilt_stop_r;
  logic       push_valid;
  frame_t     push_frame;
  frame_t     queue_head;
  logic       queue_full;
  logic       queue_empty;
  logic       queue_pop;

  // Config registers; the port never back-pressures.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_stop_r  <= STOP_CODE_RESET;
      tilt_stop_r <= STOP_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        REG_PAN_STOP:  pan_stop_r  <= cfg_wdata;
        REG_TILT_STOP: tilt_stop_r <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Input stalls only on a full queue, so a waiting sink never blocks
  // requests until the buffered frames are used up.
  assign in_stall = queue_full;

  vcfe_front u_front (
    .in_valid          (in_valid),
    .queue_full        (queue_full),
    .in_operation      (in_operation),
    .in_camera_address (in_camera_address),
    .in_pan_code       (in_pan_code),
    .in_tilt_code      (in_tilt_code),
    .in_pan_rate       (in_pan_rate),
    .in_tilt_rate      (in_tilt_rate),
    .in_direction      (in_direction),
    .in_zoom_rate      (in_zoom_rate),
    .in_enable         (in_enable),
    .in_preset_number  (in_preset_number),
    .pan_stop_code     (pan_stop_r),
    .tilt_stop_code    (tilt_stop_r),
    .push_valid        (push_valid),
    .push_frame        (push_frame)
  );

  vcfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_frame (push_frame),
    .pop        (queue_pop),
    .head       (queue_head),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  // Serializer reloads from the queue in the same cycle it sends a
  // terminator, so consecutive frames run without a bubble.
  vcfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (queue_head),
    .queue_empty    (queue_empty),
    .pop            (queue_pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

### rtl/core/vcfe_checker.sv
// Port-level checker of the frame encoder, bound to its top level.
`include "visca_command_frame_encoder_top_macros.svh"

module vcfe_checker import vcfe_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);

  logic [LEN_W-1:0] pos_r;  // byte position within the frame on the output
  logic             xfer;

  assign xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (xfer) begin
      pos_r <= out_last_byte ? '0 : pos_r + 1'b1;
    end
  end

  `VCFE_ASSERT_SAME(a_header, out_valid && pos_r == '0, out_frame_byte[7:4] == 4'h8 && !out_last_byte)
  `VCFE_ASSERT_SAME(a_second, out_valid && pos_r == LEN_W'(1), out_frame_byte == 8'h01 && !out_last_byte)
  `VCFE_ASSERT_SAME(a_term_val, out_valid && out_last_byte, out_frame_byte == TERMINATOR && pos_r >= LEN_W'(4))
  `VCFE_ASSERT_SAME(a_max_len, out_valid && pos_r == LEN_W'(BODY_MAX), out_last_byte)
  `VCFE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_frame_byte) && $stable(out_last_byte))

endmodule

bind visca_command_frame_encoder_top vcfe_checker u_vcfe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_byte (out_frame_byte),
  .out_last_byte  (out_last_byte)
);
